/* sv/mfq_pkg.sv */
// Shared types and constants for the message FIFO with rollback.
// Used by mfq_ctrl, mfq_datapath and message_fifo_with_rollback.
package mfq_pkg;

  // Field and register widths fixed by the interface
  localparam int CNT_W      = 5;   // slot count, occupancy, free slots
  localparam int LEN_W      = 7;   // message length, slot_bytes register
  localparam int ID_W       = 32;  // message id
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 2'd1;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DROP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Which result the datapath loads into the output register
  typedef enum logic [2:0] {
    LD_NONE  = 3'd0,
    LD_ENQ   = 3'd1,
    LD_EMPTY = 3'd2,
    LD_DROP  = 3'd3,
    LD_BYTE  = 3'd4
  } ld_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DROP = 2'd1,
    S_EMIT = 2'd2
  } fsm_e;

  typedef struct packed {
    cmd_e              command;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] payload_byte;
    logic              is_payload;
    logic              last_result;
    logic [CNT_W-1:0]  free_slots;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic enq;        // enqueue byte accepted
    logic op;         // pop, peek or drop accepted
    ld_e  ld;         // output register load
    logic next_byte;  // advance the byte index of the message being sent
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ring_empty;
    logic byte_last;
  } dp_stat_t;

endpackage

/* sv/mfq_datapath.sv */
// Datapath of the message FIFO: config registers, ring pointers, slot memories
// and the output register. Driven by mfq_ctrl through dp_cmd_t; uses mfq_pkg.
module mfq_datapath import mfq_pkg::*; #(
  parameter int MAX_SLOTS      = 16,
  parameter int MAX_SLOT_BYTES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_item_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output out_item_t             out_item_o
);

  localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OW    = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
  localparam int DEPTH = MAX_SLOTS << OW;

  // Control state
  logic [CNT_W-1:0] slot_count_q;
  logic [LEN_W-1:0] slot_bytes_q;
  logic [SW-1:0]    head_q, tail_q;
  logic [CNT_W-1:0] occ_q;
  logic [ID_W-1:0]  id_q;
  logic [LEN_W-1:0] plen_q;
  logic             perr_q;

  // Read side
  logic [SW-1:0]     rd_slot_q, rd_slot_d;
  logic [OW-1:0]     idx_q, idx_d;
  logic [BYTE_W-1:0] store_rd_q;
  logic [LEN_W-1:0]  len_rd_q;
  logic [ID_W-1:0]   id_rd_q;
  out_item_t         out_q, out_d;

  // Slot memories
  logic [BYTE_W-1:0] store_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem   [MAX_SLOTS];
  logic [ID_W-1:0]   id_mem    [MAX_SLOTS];

  logic [CNT_W-1:0] cap;
  logic [LEN_W-1:0] blim;
  logic             full, err_now, enq_fits, commit, cfg_hit;
  logic [SW-1:0]    tail_inc, tail_dec, head_inc;
  logic [ID_W-1:0]  id_next;
  logic [CNT_W-1:0] occ_post;
  logic [LEN_W-1:0] len_eff;

  // Effective register values
  always_comb begin
    if (slot_count_q == '0) begin
      cap = CNT_W'(1);
    end else if (int'(slot_count_q) > MAX_SLOTS) begin
      cap = CNT_W'(MAX_SLOTS);
    end else begin
      cap = slot_count_q;
    end
    if (slot_bytes_q == '0) begin
      blim = LEN_W'(1);
    end else if (int'(slot_bytes_q) > MAX_SLOT_BYTES) begin
      blim = LEN_W'(MAX_SLOT_BYTES);
    end else begin
      blim = slot_bytes_q;
    end
  end

  assign full     = occ_q >= cap;
  assign err_now  = perr_q || (plen_q >= blim);
  assign enq_fits = !err_now;
  assign commit   = cmd_i.enq && in_item_i.last_byte && !err_now && !full;
  assign cfg_hit  = cfg_valid_i &&
                    (cfg_index_i == REG_SLOT_COUNT || cfg_index_i == REG_SLOT_BYTES);

  // Ring pointer arithmetic, modulo the effective slot count
  assign tail_inc = (int'(tail_q) + 1 == int'(cap)) ? '0 : tail_q + SW'(1);
  assign head_inc = (int'(head_q) + 1 == int'(cap)) ? '0 : head_q + SW'(1);
  assign tail_dec = (tail_q == '0) ? SW'(cap - CNT_W'(1)) : tail_q - SW'(1);
  assign id_next  = (id_q == '1) ? ID_W'(1) : id_q + ID_W'(1);

  // Control state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= CNT_W'(16);
      slot_bytes_q <= LEN_W'(64);
      head_q       <= '0;
      tail_q       <= '0;
      occ_q        <= '0;
      id_q         <= ID_W'(1);
      plen_q       <= '0;
      perr_q       <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index_i == REG_SLOT_COUNT) begin
        slot_count_q <= cfg_data_i[CNT_W-1:0];
      end else begin
        slot_bytes_q <= cfg_data_i[LEN_W-1:0];
      end
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      plen_q <= '0;
      perr_q <= 1'b0;
    end else if (cmd_i.enq) begin
      if (in_item_i.last_byte) begin
        plen_q <= '0;
        perr_q <= 1'b0;
        if (commit) begin
          tail_q <= tail_inc;
          occ_q  <= occ_q + CNT_W'(1);
          id_q   <= id_next;
        end
      end else if (!perr_q) begin
        if (plen_q >= blim) begin
          perr_q <= 1'b1;
        end else begin
          plen_q <= plen_q + LEN_W'(1);
        end
      end
    end else if (cmd_i.op) begin
      plen_q <= '0;
      perr_q <= 1'b0;
      if (occ_q != '0) begin
        if (in_item_i.command == CMD_POP) begin
          head_q <= head_inc;
          occ_q  <= occ_q - CNT_W'(1);
        end else if (in_item_i.command == CMD_DROP) begin
          tail_q <= tail_dec;
          occ_q  <= occ_q - CNT_W'(1);
        end
      end
    end
  end

  // Read address: latched slot and byte index of the message being sent
  always_comb begin
    rd_slot_d = rd_slot_q;
    idx_d     = idx_q;
    if (cmd_i.op) begin
      rd_slot_d = (in_item_i.command == CMD_DROP) ? tail_dec : head_q;
      idx_d     = '0;
    end else if (cmd_i.next_byte) begin
      idx_d = idx_q + OW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_slot_d;
    idx_q     <= idx_d;
  end

  // Byte store: one write port for enqueue, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq && enq_fits && !full) begin
      store_mem[{tail_q, plen_q[OW-1:0]}] <= in_item_i.data_byte;
    end
    store_rd_q <= store_mem[{rd_slot_d, idx_d}];
  end

  // Length and id per slot, written on commit
  always_ff @(posedge clk_i) begin
    if (commit) begin
      len_mem[tail_q] <= plen_q + LEN_W'(1);
      id_mem[tail_q]  <= id_q;
    end
    len_rd_q <= len_mem[rd_slot_d];
    id_rd_q  <= id_mem[rd_slot_d];
  end

  assign len_eff = (len_rd_q == '0) ? LEN_W'(1) : len_rd_q;
  assign occ_post = commit ? occ_q + CNT_W'(1) : occ_q;

  // Output register
  always_comb begin
    out_d = out_q;
    case (cmd_i.ld)
      LD_ENQ: begin
        out_d.status       = err_now ? ST_TOO_LONG : (full ? ST_FULL : ST_OK);
        out_d.message_id   = commit ? id_q : '0;
        out_d.payload_byte = '0;
        out_d.is_payload   = 1'b0;
        out_d.last_result  = 1'b1;
        out_d.free_slots   = cap - occ_post;
      end
      LD_EMPTY: begin
        out_d.status       = ST_EMPTY;
        out_d.message_id   = '0;
        out_d.payload_byte = '0;
        out_d.is_payload   = 1'b0;
        out_d.last_result  = 1'b1;
        out_d.free_slots   = cap - occ_q;
      end
      LD_DROP: begin
        out_d.status       = ST_OK;
        out_d.message_id   = id_rd_q;
        out_d.payload_byte = '0;
        out_d.is_payload   = 1'b0;
        out_d.last_result  = 1'b1;
        out_d.free_slots   = cap - occ_q;
      end
      LD_BYTE: begin
        out_d.status       = ST_OK;
        out_d.message_id   = id_rd_q;
        out_d.payload_byte = store_rd_q;
        out_d.is_payload   = 1'b1;
        out_d.last_result  = stat_o.byte_last;
        out_d.free_slots   = cap - occ_q;
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign stat_o.ring_empty = (occ_q == '0);
  assign stat_o.byte_last  = (LEN_W'(idx_q) + LEN_W'(1) == len_eff);
  assign out_item_o        = out_q;

  // Checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap)
    else $error("occupancy above slot count");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(head_q) < int'(cap) && int'(tail_q) < int'(cap))
    else $error("ring pointer out of range");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == '0 |-> head_q == tail_q)
    else $error("empty ring with head and tail apart");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_q != '0)
    else $error("id counter reached zero");

  a_commit_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && cmd_i.ld == LD_ENQ |=> out_q.message_id != '0 && out_q.status == ST_OK)
    else $error("committed message reported without id");

endmodule

/* sv/mfq_ctrl.sv */
// Controller of the message FIFO: handshakes, output valid, command sequencing.
// Commands mfq_datapath through dp_cmd_t; uses mfq_pkg.
module mfq_ctrl import mfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Output register can take a result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.enq       = 1'b0;
    cmd_o.op        = 1'b0;
    cmd_o.ld        = LD_NONE;
    cmd_o.next_byte = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (in_item_i.command == CMD_ENQUEUE) begin
            cmd_o.enq = 1'b1;
            if (in_item_i.last_byte) begin
              cmd_o.ld = LD_ENQ;
            end
          end else begin
            cmd_o.op = 1'b1;
            if (stat_i.ring_empty) begin
              cmd_o.ld = LD_EMPTY;
            end else if (in_item_i.command == CMD_DROP) begin
              state_d = S_DROP;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_DROP: begin
        if (out_free) begin
          cmd_o.ld = LD_DROP;
          state_d  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.ld        = LD_BYTE;
          cmd_o.next_byte = 1'b1;
          if (stat_i.byte_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transaction completes
  always_comb begin
    if (cmd_o.ld != LD_NONE) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_busy_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o)
    else $error("input taken while a message is in flight");

  a_pop_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op && !stat_i.ring_empty &&
    (in_item_i.command == CMD_POP || in_item_i.command == CMD_PEEK) |=> state_q == S_EMIT)
    else $error("pop or peek did not start sending");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld != LD_NONE |-> out_free)
    else $error("output register overwritten");

endmodule

/* sv/message_fifo_with_rollback.sv */
// Message FIFO with rollback: a ring of byte-message slots with 32-bit ids.
// Top level; instantiates mfq_ctrl and mfq_datapath, uses mfq_pkg.
//
// Input channel (in_valid_i/in_ready_o, in_item_i) carries one command per
// transaction. Enqueue sends a message one byte per transaction, the final
// byte marked by last_byte; only the final byte gives a result. Pop and
// peek return one result per message byte, drop and empty cases one result.
// Output channel (out_valid_o/out_ready_i, out_item_o) is a registered stage.
// Config channel (cfg_valid_i/cfg_ready_o) writes slot_count (index 0) or
// slot_bytes (index 1); a write empties the ring and keeps the id counter.
// Write config only while the block is idle.
// Sequencing: enqueue bytes and empty results are answered from S_IDLE;
// drop goes through S_DROP; pop and peek go through S_EMIT, one byte per
// cycle while the output is free, a rate set by the single read port of
// the byte store. A result appears on the output the cycle after it is loaded.
// Reset: ring empty, ids start at 1, slot_count 16, slot_bytes 64. The slot
// memories are not cleared; only written entries are ever read.
// A stalled receiver holds the output register and the controller; no
// input is taken until the pending result can move.
module message_fifo_with_rollback import mfq_pkg::*; #(
  parameter int MAX_SLOTS      = 16,
  parameter int MAX_SLOT_BYTES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Config writes are taken at once
  assign cfg_ready_o = 1'b1;

  mfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  mfq_datapath #(
    .MAX_SLOTS      (MAX_SLOTS),
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_item_o  (out_item_o)
  );

endmodule
